/* src/rcf_pkg.sv */
// Shared types and constants for the reversible crossfade controller.
// No dependencies; every other file in src imports this package.
package rcf_pkg;

  // Field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned DUR_W   = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 8;

  // Interpolation datapath widths: span * elapsed fits in LEVEL_W + DUR_W bits
  localparam int unsigned PROD_W  = LEVEL_W + DUR_W;
  localparam int unsigned MCNT_W  = $clog2(LEVEL_W);
  localparam int unsigned DCNT_W  = $clog2(PROD_W);

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_CFE = 1'b0;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 2'd0,
    REQ_RESET   = 2'd1,
    REQ_REVERSE = 2'd2,
    REQ_DRAW    = 2'd3
  } req_t;

  // Fade phase codes (code 3 behaves as idle)
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_STARTING = 2'd1;
  localparam logic [1:0] PH_RUNNING  = 2'd2;

endpackage

/* src/rcf_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on rcf_pkg for field widths.
interface rcf_req_if import rcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DUR_W-1:0]  duration_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, req_type, duration_ms, now_ms, input ready);
  modport sink   (input valid, req_type, duration_ms, now_ms, output ready);
endinterface

interface rcf_res_if import rcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] alpha_level;
  logic               fade_done;
  logic               draw_first;
  logic [LEVEL_W-1:0] first_opacity;
  logic               draw_second;
  logic [LEVEL_W-1:0] second_opacity;
  logic               redraw_request;

  modport source (output valid, alpha_level, fade_done, draw_first, first_opacity,
                  draw_second, second_opacity, redraw_request, input ready);
  modport sink   (input valid, alpha_level, fade_done, draw_first, first_opacity,
                  draw_second, second_opacity, redraw_request, output ready);
endinterface

/* src/reversible_crossfade_controller.sv */
// Top level of the reversible crossfade controller.
// Depends on rcf_pkg, rcf_if, rcf_cfg, rcf_mul and rcf_div.
//
// Usage:
//   req : valid/ready request channel (req_type, duration_ms, now_ms).
//   res : valid/ready result channel, one result beat per request beat.
//   APB : one register at byte address 0, bit 0 = cross_fade_enable.
//         Write it only while no request is in flight.
// Sequence: start, reset, reverse and non-interpolating draws pass through
//   the elapsed, decision and output states after accept. A draw that
//   interpolates mid-fade also runs the bit-serial multiplier (one span bit
//   a cycle) and then the restoring divider (one dividend bit a cycle).
// Flow: one request at a time; ready is high only when the
//   sequencer is idle, so a new request enters in the cycle after the last
//   result was loaded into the output register.
// Reset (rst, synchronous): fade state, enable bit and channels cleared,
//   phase idle, level 0. No clearing pass.
// Stall: the result stays in the output register until taken; the next
//   request is accepted meanwhile and its result waits until the register
//   frees up.
module reversible_crossfade_controller import rcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rcf_req_if.sink            req,
  rcf_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ELAP = 6'b000010,
    ST_DEC  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;

  // Captured request
  logic [REQ_W-1:0]  req_type;
  logic [DUR_W-1:0]  duration_ms;
  logic [TIME_W-1:0] now_ms;

  // Fade state
  logic [1:0]         phase;
  logic               reversed;
  logic [TIME_W-1:0]  start_time;
  logic [LEVEL_W-1:0] from_level;
  logic [LEVEL_W-1:0] to_level;
  logic [TIME_W-1:0]  active_duration;
  logic [DUR_W-1:0]   original_duration;
  logic [LEVEL_W-1:0] level;

  // Working registers
  logic [TIME_W-1:0] elapsed;
  logic              fin;
  logic              redraw;

  logic cross_fade_enable;

  // Interpolation unit hookup
  logic               rising;
  logic [LEVEL_W-1:0] span;
  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  product;
  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] quotient;

  // Decision terms
  logic               over;
  logic               target_hit;
  logic               rev_next;
  logic               out_load;
  logic [LEVEL_W-1:0] fo_val;
  logic [LEVEL_W-1:0] so_val;
  logic               df_val;
  logic               ds_val;

  rcf_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .cross_fade_enable (cross_fade_enable)
  );

  rcf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .span    (span),
    .mcand   (elapsed[DUR_W-1:0]),
    .done    (mul_done),
    .product (product)
  );

  rcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (active_duration[DUR_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // Fade direction and level span
  assign rising = to_level >= from_level;
  assign span   = rising ? (to_level - from_level) : (from_level - to_level);

  // Fade-over and target tests against the active duration
  assign over       = active_duration[TIME_W-1] || (elapsed > active_duration);
  assign target_hit = active_duration[TIME_W-1] || (active_duration == '0) ||
                      (elapsed >= active_duration);
  assign rev_next   = ~reversed;

  assign mul_start = (state == ST_DEC) && (req_type == REQ_DRAW) &&
                     (phase == PH_RUNNING) && !target_hit;
  assign div_start = (state == ST_MUL) && mul_done;

  assign req.ready = (state == ST_IDLE);
  assign out_load  = (state == ST_OUT) && (!res.valid || res.ready);

  // Layer selection for a draw beat
  always_comb begin
    if (fin) begin
      df_val = !cross_fade_enable || (level == '0);
      fo_val = df_val ? FULL_LEVEL : '0;
      ds_val = (level == FULL_LEVEL);
      so_val = ds_val ? FULL_LEVEL : '0;
    end else begin
      df_val = 1'b1;
      fo_val = cross_fade_enable ? (FULL_LEVEL - level) : FULL_LEVEL;
      ds_val = (level != '0);
      so_val = level;
    end
  end

  // Sequencer and fade state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      phase             <= PH_IDLE;
      reversed          <= 1'b0;
      start_time        <= '0;
      from_level        <= '0;
      to_level          <= '0;
      active_duration   <= '0;
      original_duration <= '0;
      level             <= '0;
      fin               <= 1'b0;
      redraw            <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_type    <= req.req_type;
            duration_ms <= req.duration_ms;
            now_ms      <= req.now_ms;
            state       <= ST_ELAP;
          end
        end
        ST_ELAP: begin
          elapsed <= now_ms - start_time;
          state   <= ST_DEC;
        end
        ST_DEC: begin
          fin    <= 1'b1;
          redraw <= 1'b0;
          state  <= ST_OUT;
          case (req_type)
            REQ_START: begin
              from_level        <= '0;
              to_level          <= FULL_LEVEL;
              level             <= '0;
              active_duration   <= TIME_W'(duration_ms);
              original_duration <= duration_ms;
              reversed          <= 1'b0;
              phase             <= PH_STARTING;
              redraw            <= 1'b1;
            end
            REQ_RESET: begin
              level  <= '0;
              phase  <= PH_IDLE;
              redraw <= 1'b1;
            end
            REQ_REVERSE: begin
              phase <= PH_STARTING;
              if (over) begin
                if (to_level == '0) begin
                  from_level <= '0;
                  to_level   <= FULL_LEVEL;
                  level      <= '0;
                  reversed   <= 1'b0;
                end else begin
                  from_level <= FULL_LEVEL;
                  to_level   <= '0;
                  level      <= FULL_LEVEL;
                  reversed   <= 1'b1;
                end
                active_duration   <= TIME_W'(duration_ms);
                original_duration <= duration_ms;
                redraw            <= 1'b1;
              end else begin
                // Turn back mid-fade from the current level
                reversed        <= rev_next;
                from_level      <= level;
                to_level        <= rev_next ? '0 : FULL_LEVEL;
                active_duration <= rev_next ? elapsed
                                            : (TIME_W'(original_duration) - elapsed);
              end
            end
            REQ_DRAW: begin
              if (phase == PH_STARTING) begin
                start_time <= now_ms;
                phase      <= PH_RUNNING;
                fin        <= 1'b0;
                redraw     <= 1'b1;
              end else if (phase == PH_RUNNING) begin
                if (target_hit) begin
                  level <= to_level;
                end else begin
                  fin    <= 1'b0;
                  redraw <= 1'b1;
                  state  <= ST_MUL;
                end
              end
            end
            default: begin
              state <= ST_OUT;
            end
          endcase
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            level <= rising ? (from_level + quotient) : (from_level - quotient);
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: one result beat per request
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.alpha_level    <= level;
      res.redraw_request <= redraw;
      if (req_type == REQ_DRAW) begin
        res.fade_done      <= fin;
        res.draw_first     <= df_val;
        res.first_opacity  <= fo_val;
        res.draw_second    <= ds_val;
        res.second_opacity <= so_val;
      end else begin
        res.fade_done      <= 1'b0;
        res.draw_first     <= 1'b0;
        res.first_opacity  <= '0;
        res.draw_second    <= 1'b0;
        res.second_opacity <= '0;
      end
    end
  end

endmodule

/* src/rcf_cfg.sv */
// APB register block holding the cross-fade enable bit.
// Depends on rcf_pkg.
module rcf_cfg import rcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic               cross_fade_enable
);

  assign pready = 1'b1;

  // Write at the access phase; word index is paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_fade_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_CFE) begin
      cross_fade_enable <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CFE) begin
      prdata[0] = cross_fade_enable;
    end
  end

endmodule

/* src/rcf_mul.sv */
// Bit-serial shift-add multiplier: span (8 bits, MSB first) times elapsed.
// Depends on rcf_pkg. One span bit per cycle.
module rcf_mul import rcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LEVEL_W-1:0] span,
  input  logic [DUR_W-1:0]   mcand,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  logic               busy;
  logic [MCNT_W-1:0]  cnt;
  logic [LEVEL_W-1:0] sh;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MCNT_W'(LEVEL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: acc = 2*acc + bit*mcand
  always_ff @(posedge clk) begin
    if (start) begin
      sh      <= span;
      product <= '0;
    end else if (busy) begin
      sh      <= {sh[LEVEL_W-2:0], 1'b0};
      product <= {product[PROD_W-2:0], 1'b0} +
                 (sh[LEVEL_W-1] ? PROD_W'(mcand) : '0);
    end
  end

endmodule

/* src/rcf_div.sv */
// Restoring radix-2 divider, one dividend bit per cycle.
// Depends on rcf_pkg. Quotient is known to be below 256, so only 8 bits kept.
module rcf_div import rcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [DUR_W-1:0]   divisor,
  output logic               done,
  output logic [LEVEL_W-1:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [PROD_W-1:0] dsh;
  logic [DUR_W-1:0]  rem;
  logic [DUR_W:0]    trial;
  logic              fits;

  assign trial = {rem, dsh[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one bit, trial subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dsh      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dsh      <= {dsh[PROD_W-2:0], 1'b0};
      rem      <= fits ? DUR_W'(trial - {1'b0, divisor}) : DUR_W'(trial);
      quotient <= {quotient[LEVEL_W-2:0], fits};
    end
  end

endmodule
